// File: src/sgr_pkg.sv
// Package for the scaled glyph row renderer.
// Holds the sizes, codes, payload structs and the command word passed from front to back.
// No dependencies.
package sgr_pkg;

	localparam int MAX_GLYPH_WIDTH  = 12;
	localparam int MAX_GLYPH_HEIGHT = 16;
	localparam int MAX_SCALE        = 4;
	localparam int GLYPH_CODES      = 128;

	localparam int STORE_DEPTH = GLYPH_CODES * MAX_GLYPH_HEIGHT;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);

	// Field widths fixed by the interface.
	localparam int ROW_W   = 12;
	localparam int MASK_W  = 48;
	localparam int POS_W   = 16;
	localparam int GW_W    = 4;
	localparam int GH_W    = 5;
	localparam int SCALE_W = 3;
	localparam int DW_W    = 10;
	localparam int CW_W    = 6;
	localparam int CH_W    = 7;
	localparam int N_W     = CH_W - 1;

	localparam int K_W = (MAX_GLYPH_HEIGHT > 1) ? $clog2(MAX_GLYPH_HEIGHT) : 1;
	localparam int R_W = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;

	// The queue depth must be a power of two so that the pointers wrap by themselves.
	localparam int QUEUE_DEPTH = 4;
	localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);
	localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

	localparam logic [1:0] KIND_LOAD   = 2'd0;
	localparam logic [1:0] KIND_DRAW   = 2'd1;
	localparam logic [1:0] KIND_SETCUR = 2'd2;

	localparam logic [7:0] CODE_NEWLINE = 8'd10;
	localparam logic [7:0] CODE_FIRST   = 8'd32;
	localparam logic [7:0] CODE_LAST    = 8'd127;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = DW_W;
	localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_WIDTH   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_HEIGHT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SCALE         = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_DISPLAY_WIDTH = 2'd3;

	localparam logic [GW_W-1:0]    RST_GLYPH_WIDTH   = 4'd8;
	localparam logic [GH_W-1:0]    RST_GLYPH_HEIGHT  = 5'd8;
	localparam logic [SCALE_W-1:0] RST_SCALE         = 3'd1;
	localparam logic [DW_W-1:0]    RST_DISPLAY_WIDTH = 10'd320;

	typedef struct packed {
		logic [1:0]       kind;
		logic [7:0]       code;
		logic [3:0]       row;
		logic [ROW_W-1:0] row_bits;
		logic [POS_W-1:0] pos_x;
		logic [POS_W-1:0] pos_y;
	} in_t;

	typedef struct packed {
		logic [POS_W-1:0]  x;
		logic [POS_W-1:0]  y;
		logic [CW_W-1:0]   width;
		logic [MASK_W-1:0] mask;
		logic              last;
	} out_t;

	// Effective (clamped) configuration and the derived character size.
	typedef struct packed {
		logic [GW_W-1:0]    gw;
		logic [GH_W-1:0]    gh;
		logic [SCALE_W-1:0] s;
		logic [CW_W-1:0]    cw;
		logic [CH_W-1:0]    ch;
		logic [DW_W-1:0]    dw;
	} cfg_t;

	typedef enum logic [1:0] {
		OP_LOAD    = 2'd0,
		OP_DRAW    = 2'd1,
		OP_SETCUR  = 2'd2,
		OP_NEWLINE = 2'd3
	} op_t;

	typedef struct packed {
		op_t               op;
		logic [ADDR_W-1:0] addr;
		logic [ROW_W-1:0]  bits;
		logic [POS_W-1:0]  pos_x;
		logic [POS_W-1:0]  pos_y;
	} cmd_t;

endpackage

// File: src/sgr_front.sv
// Front end of the glyph renderer: takes input words, decodes them into commands.
// Ignored words are dropped here. Depends on sgr_pkg.
module sgr_front (
	input  logic          in_valid,
	output logic          in_stall,
	input  sgr_pkg::in_t  in_data,
	input  sgr_pkg::cfg_t cfg,
	input  logic          q_full,
	output logic          push,
	output sgr_pkg::cmd_t cmd
);

	logic                       keep;
	logic [sgr_pkg::ADDR_W-1:0] base;
	logic                       printable;

	assign in_stall = q_full;

	always_comb begin
		base      = sgr_pkg::ADDR_W'(in_data.code) * sgr_pkg::ADDR_W'(cfg.gh);
		printable = (in_data.code >= sgr_pkg::CODE_FIRST) && (in_data.code <= sgr_pkg::CODE_LAST);
		keep      = 1'b0;
		cmd.op    = sgr_pkg::OP_LOAD;
		cmd.addr  = base + sgr_pkg::ADDR_W'(in_data.row);
		cmd.bits  = in_data.row_bits;
		cmd.pos_x = in_data.pos_x;
		cmd.pos_y = in_data.pos_y;
		case (in_data.kind)
			sgr_pkg::KIND_LOAD: begin
				// Rows past the glyph height and codes past the store are dropped.
				keep = ({1'b0, in_data.row} < cfg.gh) &&
				       (int'(in_data.code) < sgr_pkg::GLYPH_CODES);
			end
			sgr_pkg::KIND_SETCUR: begin
				keep   = 1'b1;
				cmd.op = sgr_pkg::OP_SETCUR;
			end
			sgr_pkg::KIND_DRAW: begin
				if (in_data.code == sgr_pkg::CODE_NEWLINE) begin
					keep   = 1'b1;
					cmd.op = sgr_pkg::OP_NEWLINE;
				end else if (printable) begin
					keep     = 1'b1;
					cmd.op   = sgr_pkg::OP_DRAW;
					cmd.addr = base;
				end
			end
			default: keep = 1'b0;
		endcase
		push = in_valid && !q_full && keep;
	end

endmodule

// File: src/sgr_queue.sv
// Short command queue between the front and back of the glyph renderer.
// Register file with head and tail pointers. Depends on sgr_pkg.
module sgr_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  sgr_pkg::cmd_t push_cmd,
	input  logic          pop,
	output sgr_pkg::cmd_t head,
	output logic          empty,
	output logic          full
);

	sgr_pkg::cmd_t                entry_q [sgr_pkg::QUEUE_DEPTH];
	logic [sgr_pkg::Q_PTR_W-1:0]  wr_ptr_q;
	logic [sgr_pkg::Q_PTR_W-1:0]  rd_ptr_q;
	logic [sgr_pkg::Q_CNT_W-1:0]  count_q;

	assign empty = (count_q == '0);
	assign full  = (count_q == sgr_pkg::Q_CNT_W'(sgr_pkg::QUEUE_DEPTH));
	assign head  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: src/sgr_back.sv
// Back end of the glyph renderer: font store, text cursor and the row emitter.
// Executes queued commands and drives the output register. Depends on sgr_pkg.
module sgr_back (
	input  logic          clk,
	input  logic          arst_n,
	input  sgr_pkg::cfg_t cfg,
	input  logic          q_empty,
	input  sgr_pkg::cmd_t q_head,
	output logic          q_pop,
	output logic          out_valid,
	input  logic          out_stall,
	output sgr_pkg::out_t out_data
);

	localparam int EXT_W = (sgr_pkg::MAX_GLYPH_WIDTH > sgr_pkg::ROW_W) ?
	                       sgr_pkg::MAX_GLYPH_WIDTH : sgr_pkg::ROW_W;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_EMIT = 3'b010,
		ST_ADV  = 3'b100
	} state_t;

	state_t                          state_q;
	logic [sgr_pkg::ROW_W-1:0]       store_q [sgr_pkg::STORE_DEPTH];
	logic [sgr_pkg::ROW_W-1:0]       rdata_q;
	logic [sgr_pkg::ADDR_W-1:0]      base_q;
	logic [sgr_pkg::K_W-1:0]         k_q;
	logic [sgr_pkg::R_W-1:0]         r_q;
	logic [sgr_pkg::N_W-1:0]         n_q;
	logic [sgr_pkg::POS_W-1:0]       cursor_col_q;
	logic [sgr_pkg::POS_W-1:0]       cursor_line_q;
	logic                            out_valid_q;
	sgr_pkg::out_t                   out_q;

	logic                            fire;
	logic                            row_end;
	logic                            glyph_end;
	logic                            last_row;
	logic                            rd_en;
	logic                            wr_en;
	logic [sgr_pkg::ADDR_W-1:0]      raddr;
	logic [sgr_pkg::POS_W-1:0]       col_next;
	logic                            wrap;

	// Each glyph bit becomes a run of s pixels; bits past the glyph width are dropped.
	function automatic logic [sgr_pkg::MASK_W-1:0] widen(
		input logic [sgr_pkg::ROW_W-1:0]   bits,
		input logic [sgr_pkg::GW_W-1:0]    gw,
		input logic [sgr_pkg::SCALE_W-1:0] s
	);
		logic [sgr_pkg::MASK_W-1:0] m;
		logic [EXT_W-1:0]           ext;
		int                         pos;
		m   = '0;
		ext = EXT_W'(bits);
		for (int b = 0; b < sgr_pkg::MAX_GLYPH_WIDTH; b++) begin
			for (int r = 0; r < sgr_pkg::MAX_SCALE; r++) begin
				pos = b * int'(s) + r;
				if (ext[b] && b < int'(gw) && r < int'(s) && pos < sgr_pkg::MASK_W) begin
					m[pos] = 1'b1;
				end
			end
		end
		return m;
	endfunction

	always_comb begin
		q_pop     = (state_q == ST_IDLE) && !q_empty;
		fire      = (state_q == ST_EMIT) && (!out_valid_q || !out_stall);
		row_end   = (sgr_pkg::SCALE_W'(r_q) == cfg.s - 3'd1);
		glyph_end = (sgr_pkg::GH_W'(k_q) == cfg.gh - 5'd1);
		last_row  = (sgr_pkg::CH_W'(n_q) + 7'd1 == cfg.ch);
		wr_en     = q_pop && (q_head.op == sgr_pkg::OP_LOAD);
		rd_en     = 1'b0;
		raddr     = q_head.addr;
		if (q_pop && q_head.op == sgr_pkg::OP_DRAW) begin
			rd_en = 1'b1;
		end else if (fire && row_end && !glyph_end) begin
			// Fetch the next glyph row while the last copy of this one goes out.
			rd_en = 1'b1;
			raddr = base_q + sgr_pkg::ADDR_W'(k_q) + sgr_pkg::ADDR_W'(1);
		end
		col_next = cursor_col_q + sgr_pkg::POS_W'(cfg.cw);
		wrap     = $signed({1'b0, col_next}) >
		           ($signed({7'b0, cfg.dw}) - $signed({11'b0, cfg.cw}));
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			store_q[q_head.addr] <= q_head.bits;
		end
		if (rd_en) begin
			rdata_q <= store_q[raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && q_head.op == sgr_pkg::OP_DRAW) begin
			base_q <= q_head.addr;
		end
		if (fire) begin
			out_q.x     <= cursor_col_q;
			out_q.y     <= cursor_line_q + sgr_pkg::POS_W'(n_q);
			out_q.width <= cfg.cw;
			out_q.mask  <= widen(rdata_q, cfg.gw, cfg.s);
			out_q.last  <= last_row;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			k_q           <= '0;
			r_q           <= '0;
			n_q           <= '0;
			cursor_col_q  <= '0;
			cursor_line_q <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (q_pop) begin
						case (q_head.op)
							sgr_pkg::OP_SETCUR: begin
								cursor_col_q  <= q_head.pos_x;
								cursor_line_q <= q_head.pos_y;
							end
							sgr_pkg::OP_NEWLINE: begin
								cursor_col_q  <= '0;
								cursor_line_q <= cursor_line_q + sgr_pkg::POS_W'(cfg.ch);
							end
							sgr_pkg::OP_DRAW: begin
								k_q     <= '0;
								r_q     <= '0;
								n_q     <= '0;
								state_q <= ST_EMIT;
							end
							default: ;
						endcase
					end
				end
				ST_EMIT: begin
					if (fire) begin
						n_q <= n_q + 1'b1;
						if (row_end) begin
							r_q <= '0;
							k_q <= k_q + 1'b1;
							if (glyph_end) begin
								state_q <= ST_ADV;
							end
						end else begin
							r_q <= r_q + 1'b1;
						end
					end
				end
				ST_ADV: begin
					if (wrap) begin
						cursor_col_q  <= '0;
						cursor_line_q <= cursor_line_q + sgr_pkg::POS_W'(cfg.ch);
					end else begin
						cursor_col_q <= col_next;
					end
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// File: src/scaled_glyph_row_renderer.sv
// Top level of the scaled glyph row renderer: configuration registers and clamping,
// front decoder, command queue and back end. Depends on sgr_pkg, sgr_front, sgr_queue, sgr_back.
//
//   Channel   Handshake              Word
//   in        in_valid / in_stall    in_data   (load row, draw code, set cursor)
//   out       out_valid / out_stall  out_data  (one scaled pixel row)
//   config    cfg_we                 cfg_index, cfg_data
//
// In the back end a printable character pops its command, emits glyph_height * scale output
// rows, one per scaled glyph row, and then advances the cursor.
// Loads, cursor moves and newlines are done as their command is popped; a four-entry queue lets
// the front keep accepting while a character is being drawn.
// Reset clears the cursor and queue, presets the config; the font store has no reset and
// needs no clearing pass. A stalled output holds its row and pauses the emitter.
module scaled_glyph_row_renderer (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  sgr_pkg::in_t                      in_data,
	output logic                              out_valid,
	input  logic                              out_stall,
	output sgr_pkg::out_t                     out_data,
	input  logic                              cfg_we,
	input  logic [sgr_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [sgr_pkg::CFG_DATA_W-1:0]    cfg_data
);

	logic [sgr_pkg::GW_W-1:0]    glyph_width_q;
	logic [sgr_pkg::GH_W-1:0]    glyph_height_q;
	logic [sgr_pkg::SCALE_W-1:0] scale_q;
	logic [sgr_pkg::DW_W-1:0]    display_width_q;

	sgr_pkg::cfg_t cfg;
	sgr_pkg::cmd_t push_cmd;
	sgr_pkg::cmd_t q_head;
	logic          push;
	logic          pop;
	logic          q_empty;
	logic          q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			glyph_width_q   <= sgr_pkg::RST_GLYPH_WIDTH;
			glyph_height_q  <= sgr_pkg::RST_GLYPH_HEIGHT;
			scale_q         <= sgr_pkg::RST_SCALE;
			display_width_q <= sgr_pkg::RST_DISPLAY_WIDTH;
		end else if (cfg_we) begin
			case (cfg_index)
				sgr_pkg::CFG_GLYPH_WIDTH:   glyph_width_q   <= cfg_data[sgr_pkg::GW_W-1:0];
				sgr_pkg::CFG_GLYPH_HEIGHT:  glyph_height_q  <= cfg_data[sgr_pkg::GH_W-1:0];
				sgr_pkg::CFG_SCALE:         scale_q         <= cfg_data[sgr_pkg::SCALE_W-1:0];
				sgr_pkg::CFG_DISPLAY_WIDTH: display_width_q <= cfg_data[sgr_pkg::DW_W-1:0];
				default: ;
			endcase
		end
	end

	// Zero acts as one, and values above the font limits are held at the limit.
	always_comb begin
		if (glyph_width_q == '0) begin
			cfg.gw = sgr_pkg::GW_W'(1);
		end else if (int'(glyph_width_q) > sgr_pkg::MAX_GLYPH_WIDTH) begin
			cfg.gw = sgr_pkg::GW_W'(sgr_pkg::MAX_GLYPH_WIDTH);
		end else begin
			cfg.gw = glyph_width_q;
		end
		if (glyph_height_q == '0) begin
			cfg.gh = sgr_pkg::GH_W'(1);
		end else if (int'(glyph_height_q) > sgr_pkg::MAX_GLYPH_HEIGHT) begin
			cfg.gh = sgr_pkg::GH_W'(sgr_pkg::MAX_GLYPH_HEIGHT);
		end else begin
			cfg.gh = glyph_height_q;
		end
		if (scale_q == '0) begin
			cfg.s = sgr_pkg::SCALE_W'(1);
		end else if (int'(scale_q) > sgr_pkg::MAX_SCALE) begin
			cfg.s = sgr_pkg::SCALE_W'(sgr_pkg::MAX_SCALE);
		end else begin
			cfg.s = scale_q;
		end
		cfg.cw = sgr_pkg::CW_W'(cfg.gw) * sgr_pkg::CW_W'(cfg.s);
		cfg.ch = sgr_pkg::CH_W'(cfg.gh) * sgr_pkg::CH_W'(cfg.s);
		cfg.dw = display_width_q;
	end

	sgr_front u_front (
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.cfg      (cfg),
		.q_full   (q_full),
		.push     (push),
		.cmd      (push_cmd)
	);

	sgr_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (q_head),
		.empty    (q_empty),
		.full     (q_full)
	);

	sgr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.q_empty   (q_empty),
		.q_head    (q_head),
		.q_pop     (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule
